[rtl/core/bmpr_pkg.sv]
// ----------------------------------------------------------------------------
// bmpr_pkg: shared types and constants of the bmp rle8 decoder
// result record, push request between parser and output queue, codes
// ----------------------------------------------------------------------------
package bmpr_pkg;

    // configuration register file
    localparam int CFG_W      = 13;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DIM_RST = 4096;

    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 1'b1;

    // default size limits
    localparam int DEF_MAX_WIDTH  = 4096;
    localparam int DEF_MAX_HEIGHT = 4096;

    // result field widths
    localparam int OUT_POS_W = 12;
    localparam int OUT_POS_MAX = (1 << OUT_POS_W) - 1;
    localparam int BYTE_W    = 8;

    typedef enum logic [1:0] {
        KIND_RUN = 2'd0,
        KIND_EOL = 2'd1,
        KIND_EOI = 2'd2
    } t_kind;

    // parser phase, one-hot
    typedef enum logic [5:0] {
        PH_COUNT = 6'b000001,
        PH_VALUE = 6'b000010,
        PH_DX    = 6'b000100,
        PH_DY    = 6'b001000,
        PH_LIT   = 6'b010000,
        PH_PAD   = 6'b100000
    } t_phase;

    // escape codes after a zero count byte
    localparam logic [BYTE_W-1:0] ESC_EOL   = 8'd0;
    localparam logic [BYTE_W-1:0] ESC_EOI   = 8'd1;
    localparam logic [BYTE_W-1:0] ESC_DELTA = 8'd2;

    typedef struct packed {
        t_kind                 kind;
        logic [OUT_POS_W-1:0]  row;
        logic [OUT_POS_W-1:0]  column;
        logic [BYTE_W-1:0]     run_length;
        logic [BYTE_W-1:0]     pixel_value;
        logic                  clipped;
        logic                  last;
    } t_result;

    // up to two results per accepted byte
    typedef struct packed {
        logic [1:0] n;
        t_result    e0;
        t_result    e1;
    } t_push;

endpackage

[rtl/core/bmpr_in_if.sv]
// ----------------------------------------------------------------------------
// bmpr_in_if: compressed byte channel
// valid/ready handshake carrying one stream byte per beat
// ----------------------------------------------------------------------------
interface bmpr_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] stream_byte;
    logic       start_of_image;

    modport source (output valid, output stream_byte, output start_of_image, input ready);
    modport sink   (input valid, input stream_byte, input start_of_image, output ready);
endinterface

[rtl/core/bmpr_out_if.sv]
// ----------------------------------------------------------------------------
// bmpr_out_if: run descriptor channel
// valid/ready handshake carrying one run or end mark per beat
// ----------------------------------------------------------------------------
interface bmpr_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [11:0] row;
    logic [11:0] column;
    logic [7:0]  run_length;
    logic [7:0]  pixel_value;
    logic        clipped;
    logic        last;

    modport source (output valid, output kind, output row, output column,
                    output run_length, output pixel_value, output clipped,
                    output last, input ready);
    modport sink   (input valid, input kind, input row, input column,
                    input run_length, input pixel_value, input clipped,
                    input last, output ready);
endinterface

[rtl/core/bmp_rle8_decoder_top.sv]
// ----------------------------------------------------------------------------
// bmp_rle8_decoder_top: bmp rle8 stream decoder
// parses an rle8 pixel stream byte by byte into run descriptors and marks
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake           beat content
//  i_byte    in   valid/ready         stream_byte, start_of_image
//  o_run     out  valid/ready         kind, row, column, run_length,
//                                     pixel_value, clipped, last
//  i_cfg_*   in   write enable only   image_width (0), image_height (1)
//
//  one byte a cycle while the queue has room: the parser state updates in the cycle a byte is taken,
//  its results land in a four-entry queue and leave one per output beat
//  i_byte.ready is high while the queue holds two or fewer results, so a
//  byte that makes two results (run plus end of line) is always stored
//  reset (synchronous, active low) empties the queue and puts the parser at
//  the bottom row, column 0, awaiting a count byte; widths reset to 4096
//  a stalled output only stops input once three results wait; results keep order
//
module bmp_rle8_decoder_top
    import bmpr_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    bmpr_in_if.sink              i_byte,
    bmpr_out_if.source           o_run,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_wdata
);

    // configuration registers, read live by the parser
    logic [CFG_W-1:0] r_image_width;
    logic [CFG_W-1:0] r_image_height;

    logic  room;
    logic  accept;
    t_push push;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width  <= CFG_W'(CFG_DIM_RST);
            r_image_height <= CFG_W'(CFG_DIM_RST);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_IMAGE_WIDTH:  r_image_width  <= i_cfg_wdata;
                CFG_IMAGE_HEIGHT: r_image_height <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // input beat taken whenever the queue has space for two results
    assign i_byte.ready = room;
    assign accept       = i_byte.valid && room;

    bmpr_parser #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_parser (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_accept         (accept),
        .i_stream_byte    (i_byte.stream_byte),
        .i_start_of_image (i_byte.start_of_image),
        .i_image_width    (r_image_width),
        .i_image_height   (r_image_height),
        .o_push           (push)
    );

    bmpr_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_room  (room),
        .o_run   (o_run)
    );

endmodule

[rtl/core/bmpr_parser.sv]
// ----------------------------------------------------------------------------
// bmpr_parser: rle8 command parser
// holds phase, position and counts; turns one byte into up to two results
// ----------------------------------------------------------------------------
module bmpr_parser
    import bmpr_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic [BYTE_W-1:0] i_stream_byte,
    input  logic              i_start_of_image,
    input  logic [CFG_W-1:0]  i_image_width,
    input  logic [CFG_W-1:0]  i_image_height,
    output t_push             o_push
);

    localparam int CW  = $clog2(MAX_WIDTH + 256);
    localparam int RW  = $clog2(MAX_HEIGHT);
    localparam int HB  = $clog2(MAX_HEIGHT + 1);
    localparam int WW  = (CW > CFG_W) ? CW : CFG_W;
    localparam int HW  = (HB > CFG_W) ? HB : CFG_W;
    localparam int SWC = (CW > OUT_POS_W) ? CW : OUT_POS_W;
    localparam int SWR = (RW > OUT_POS_W) ? RW : OUT_POS_W;
    localparam int ROW_RST = ((CFG_DIM_RST > MAX_HEIGHT) ? MAX_HEIGHT : CFG_DIM_RST) - 1;

    t_phase            r_phase, n_phase;
    logic [BYTE_W-1:0] r_held, n_held;
    logic [CW-1:0]     r_col, n_col;
    logic [RW-1:0]     r_row, n_row;
    logic [BYTE_W-1:0] r_lit, n_lit;
    logic              r_pad, n_pad;
    logic              r_done, n_done;

    logic [WW-1:0] w_x;
    logic [CW-1:0] w_eff;
    logic [HW-1:0] h_x;
    logic [HW-1:0] h_eff;
    logic [RW-1:0] row_init;
    t_push         push;

    function automatic logic [OUT_POS_W-1:0] sat_col(input logic [CW-1:0] v);
        logic [SWC-1:0] x;
        x = SWC'(v);
        return (x > SWC'(OUT_POS_MAX)) ? OUT_POS_W'(OUT_POS_MAX) : x[OUT_POS_W-1:0];
    endfunction

    function automatic logic [OUT_POS_W-1:0] sat_row(input logic [RW-1:0] v);
        logic [SWR-1:0] x;
        x = SWR'(v);
        return (x > SWR'(OUT_POS_MAX)) ? OUT_POS_W'(OUT_POS_MAX) : x[OUT_POS_W-1:0];
    endfunction

    // clamp the dimension registers
    assign w_x = WW'(i_image_width);
    assign w_eff = (w_x == '0) ? CW'(1) :
                   (w_x > WW'(MAX_WIDTH)) ? CW'(MAX_WIDTH) : CW'(w_x);
    assign h_x = HW'(i_image_height);
    assign h_eff = (h_x == '0) ? HW'(1) :
                   (h_x > HW'(MAX_HEIGHT)) ? HW'(MAX_HEIGHT) : h_x;
    assign row_init = RW'(h_eff - HW'(1));

    always_comb begin
        t_phase            c_phase;
        logic [BYTE_W-1:0] c_held;
        logic [CW-1:0]     c_col;
        logic [RW-1:0]     c_row;
        logic [BYTE_W-1:0] c_lit;
        logic              c_pad;
        logic              c_done;
        logic [BYTE_W-1:0] b;
        logic              have_run;
        logic [BYTE_W-1:0] run_cnt;
        logic [CW-1:0]     avail;
        logic [CW-1:0]     run_len;
        logic              do_cmd;
        logic              force_line;
        logic [CW-1:0]     cmd_col;
        logic [RW-1:0]     cmd_row;
        logic              do_eoi;
        logic [RW-1:0]     eoi_row;
        logic              do_eol;
        logic [BYTE_W-1:0] lit_nx;
        t_result           run_res;
        t_result           tail_res;

        b = i_stream_byte;
        if (i_start_of_image) begin
            c_phase = PH_COUNT;
            c_held  = '0;
            c_col   = '0;
            c_row   = row_init;
            c_lit   = '0;
            c_pad   = 1'b0;
            c_done  = 1'b0;
        end else begin
            c_phase = r_phase;
            c_held  = r_held;
            c_col   = r_col;
            c_row   = r_row;
            c_lit   = r_lit;
            c_pad   = r_pad;
            c_done  = r_done;
        end

        n_phase = c_phase;
        n_held  = c_held;
        n_col   = c_col;
        n_row   = c_row;
        n_lit   = c_lit;
        n_pad   = c_pad;
        n_done  = c_done;

        have_run   = 1'b0;
        run_cnt    = '0;
        do_cmd     = 1'b0;
        force_line = 1'b0;
        cmd_col    = c_col;
        cmd_row    = c_row;
        do_eoi     = 1'b0;
        eoi_row    = c_row;
        do_eol     = 1'b0;
        lit_nx     = '0;

        if (!c_done) begin
            unique case (c_phase)
                PH_COUNT: begin
                    n_held  = b;
                    n_phase = PH_VALUE;
                end
                PH_VALUE: begin
                    if (c_held != '0) begin
                        have_run = 1'b1;
                        run_cnt  = c_held;
                        do_cmd   = 1'b1;
                        cmd_col  = c_col + CW'(c_held);
                    end else if (b == ESC_EOL) begin
                        do_cmd     = 1'b1;
                        force_line = 1'b1;
                    end else if (b == ESC_EOI) begin
                        do_eoi = 1'b1;
                    end else if (b == ESC_DELTA) begin
                        n_phase = PH_DX;
                    end else begin
                        n_lit   = b;
                        n_pad   = b[0];
                        n_phase = PH_LIT;
                    end
                end
                PH_DX: begin
                    n_held  = b;
                    n_phase = PH_DY;
                end
                PH_DY: begin
                    if (SWR'(b) > SWR'(c_row)) begin
                        do_eoi  = 1'b1;
                        eoi_row = '0;
                    end else begin
                        do_cmd  = 1'b1;
                        cmd_row = c_row - RW'(b);
                        cmd_col = c_col + CW'(c_held);
                    end
                end
                PH_LIT: begin
                    have_run = 1'b1;
                    run_cnt  = 8'd1;
                    lit_nx   = (c_lit != '0) ? c_lit - 8'd1 : '0;
                    n_lit    = lit_nx;
                    n_col    = c_col + CW'(1);
                    if (lit_nx == '0) begin
                        if (c_pad) begin
                            n_phase = PH_PAD;
                        end else begin
                            do_cmd  = 1'b1;
                            cmd_col = c_col + CW'(1);
                        end
                    end
                end
                PH_PAD: begin
                    n_pad  = 1'b0;
                    do_cmd = 1'b1;
                end
                default: begin
                    n_phase = PH_COUNT;
                end
            endcase
        end

        // end of command: a column past the width or an end-of-line escape ends the line, or the image on row 0
        if (do_cmd) begin
            n_col   = cmd_col;
            n_row   = cmd_row;
            n_phase = PH_COUNT;
            if (force_line || (cmd_col > w_eff)) begin
                if (cmd_row == '0) begin
                    do_eoi  = 1'b1;
                    eoi_row = '0;
                end else begin
                    do_eol = 1'b1;
                    n_row  = cmd_row - RW'(1);
                    n_col  = '0;
                end
            end
        end
        if (do_eoi) begin
            n_done  = 1'b1;
            n_phase = PH_COUNT;
        end

        // run record, clipped at the row end
        avail   = (c_col < w_eff) ? w_eff - c_col : '0;
        run_len = (CW'(run_cnt) < avail) ? CW'(run_cnt) : avail;

        run_res.kind        = KIND_RUN;
        run_res.row         = sat_row(c_row);
        run_res.column      = sat_col(c_col);
        run_res.run_length  = run_len[BYTE_W-1:0];
        run_res.pixel_value = b;
        run_res.clipped     = (CW'(run_cnt) > avail);
        run_res.last        = !(do_eol || do_eoi);

        tail_res.kind        = do_eoi ? KIND_EOI : KIND_EOL;
        tail_res.row         = do_eoi ? sat_row(eoi_row) : sat_row(cmd_row);
        tail_res.column      = '0;
        tail_res.run_length  = '0;
        tail_res.pixel_value = '0;
        tail_res.clipped     = 1'b0;
        tail_res.last        = 1'b1;

        push.e0 = have_run ? run_res : tail_res;
        push.e1 = tail_res;
        push.n  = i_accept ? (2'(have_run) + 2'(do_eol || do_eoi)) : 2'd0;
    end

    assign o_push = push;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_COUNT;
            r_held  <= '0;
            r_col   <= '0;
            r_row   <= RW'(ROW_RST);
            r_lit   <= '0;
            r_pad   <= 1'b0;
            r_done  <= 1'b0;
        end else if (i_accept) begin
            r_phase <= n_phase;
            r_held  <= n_held;
            r_col   <= n_col;
            r_row   <= n_row;
            r_lit   <= n_lit;
            r_pad   <= n_pad;
            r_done  <= n_done;
        end
    end

    // a finished image stays silent until the next start
    a_done_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_done && !i_start_of_image) |-> (push.n == 2'd0))
        else $error("result pushed after end of image");

    // two results: a run followed by the closing mark
    a_pair_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push.n == 2'd2) |-> (push.e0.kind == KIND_RUN && !push.e0.last &&
                              push.e1.kind != KIND_RUN && push.e1.last))
        else $error("bad result pair");

    // end of image always sets the done flag
    a_eoi_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && push.n != 2'd0 &&
         ((push.n == 2'd1 && push.e0.kind == KIND_EOI) ||
          (push.n == 2'd2 && push.e1.kind == KIND_EOI))) |=> r_done)
        else $error("end of image without done flag");

endmodule

[rtl/core/bmpr_outq.sv]
// ----------------------------------------------------------------------------
// bmpr_outq: result queue
// four-entry buffer taking up to two results a cycle while it has room, one out per beat
// ----------------------------------------------------------------------------
module bmpr_outq
    import bmpr_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_push             i_push,
    output logic              o_room,
    bmpr_out_if.source        o_run
);

    t_result    r_mem [4];
    logic [1:0] r_wptr, n_wptr;
    logic [1:0] r_rptr, n_rptr;
    logic [2:0] r_cnt, n_cnt;
    logic       pop;
    t_result    head;

    assign pop    = o_run.valid && o_run.ready;
    assign n_wptr = r_wptr + i_push.n;
    assign n_rptr = r_rptr + 2'(pop);
    assign n_cnt  = r_cnt + 3'(i_push.n) - 3'(pop);

    // room for a worst case byte
    assign o_room = (r_cnt <= 3'd2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            r_wptr <= n_wptr;
            r_rptr <= n_rptr;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.n != 2'd0) begin
            r_mem[r_wptr] <= i_push.e0;
        end
        if (i_push.n == 2'd2) begin
            r_mem[r_wptr + 2'd1] <= i_push.e1;
        end
    end

    assign head = r_mem[r_rptr];

    assign o_run.valid       = (r_cnt != '0);
    assign o_run.kind        = head.kind;
    assign o_run.row         = head.row;
    assign o_run.column      = head.column;
    assign o_run.run_length  = head.run_length;
    assign o_run.pixel_value = head.pixel_value;
    assign o_run.clipped     = head.clipped;
    assign o_run.last        = head.last;

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 3'd4)
        else $error("result queue overflow");

    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push.n != 2'd0) |-> (r_cnt <= 3'd2))
        else $error("push without room");

    a_ptr_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 3'd0 || r_cnt == 3'd4) |-> (r_wptr == r_rptr))
        else $error("queue pointers out of step with count");

endmodule
